### rtl/kmptt_pkg.sv
// Shared types and constants for the keyed max-priority task table.
package kmptt_pkg;

    localparam int TASK_SLOTS = 256;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int KEY_W      = 8;
    localparam int OWNER_W    = 16;
    localparam int PRIO_W     = 31;
    localparam int STATUS_W   = 2;
    localparam int CMP_W      = (SLOT_W > KEY_W) ? SLOT_W : KEY_W;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_EDIT   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_EXEC   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   task_key;
        logic [OWNER_W-1:0] owner_in;
        logic [PRIO_W-1:0]  prio_in;
    } t_in;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner_out;
        logic [STATUS_W-1:0] status;
    } t_out;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               add;
        logic               edit;
        logic               clear;
        logic [CMP_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
        logic [PRIO_W-1:0]  prio;
    } t_cell_cmd;

    // Running best entry handed from cell to cell.
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  idx;
        logic [PRIO_W-1:0]  prio;
        logic [OWNER_W-1:0] owner;
    } t_tok;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

### rtl/kmptt_cell.sv
// One table slot: holds an entry and folds it into the running maximum.
module kmptt_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [kmptt_pkg::SLOT_W-1:0] i_idx,
    input  kmptt_pkg::t_cell_cmd         i_cmd,
    input  kmptt_pkg::t_tok              i_tok,
    output kmptt_pkg::t_tok              o_tok,
    output logic                         o_hit
);

    logic                             r_valid;
    logic                             n_valid;
    logic [kmptt_pkg::OWNER_W-1:0]    r_owner;
    logic [kmptt_pkg::PRIO_W-1:0]     r_prio;
    kmptt_pkg::t_tok                  r_tok;
    kmptt_pkg::t_tok                  n_tok;
    logic                             match;
    logic                             take;

    assign match = (kmptt_pkg::CMP_W'(i_idx) == i_cmd.key);
    assign o_hit = r_valid && match;

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.add && match) begin
            n_valid = 1'b1;
        end else if (i_cmd.clear && match) begin
            n_valid = 1'b0;
        end
    end

    // A later slot wins a tie, so equal priority replaces the incoming best.
    assign take = r_valid && (!i_tok.found || (r_prio >= i_tok.prio));

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_idx;
            n_tok.prio  = r_prio;
            n_tok.owner = r_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.found <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_tok.found <= n_tok.found;
        end
        r_tok.idx   <= n_tok.idx;
        r_tok.prio  <= n_tok.prio;
        r_tok.owner <= n_tok.owner;
        if (i_cmd.add && match) begin
            r_owner <= i_cmd.owner;
            r_prio  <= i_cmd.prio;
        end else if (i_cmd.edit && match && r_valid) begin
            r_prio  <= i_cmd.prio;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/keyed_max_priority_task_table.sv
// Keyed max-priority task table: a chain of slot cells and its sequencer.
//
// Input channel (i_valid, o_stall, i_data) carries one command per
// transaction: add, edit priority, remove, or execute the top task.
// Output channel (o_valid, i_stall, o_data) returns exactly one result
// transaction per command, in order.
// Add, edit and remove update the addressed cell and load their result into
// the output register at the same clock edge; the block can take such a
// command every cycle while the output is drained.
// Execute passes a running-best token through the chain of TASK_SLOTS cells,
// one cell per cycle; the sequencer waits in S_SCAN while the token crosses
// the chain, then loads the result in S_FIN once the output register is
// free. The winning slot is cleared when its result is loaded.
// Reset clears every valid bit; the table accepts commands as soon as
// reset is released. While i_stall holds a result, o_data stays put and the
// block accepts no command that would need the output register.
module keyed_max_priority_task_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  kmptt_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output kmptt_pkg::t_out  o_data
);

    kmptt_pkg::t_tok                  tok [kmptt_pkg::TASK_SLOTS+1];
    logic [kmptt_pkg::TASK_SLOTS-1:0] hits;
    kmptt_pkg::t_cell_cmd             cmd;

    kmptt_pkg::t_state                r_state;
    kmptt_pkg::t_state                n_state;
    logic [kmptt_pkg::SLOT_W-1:0]     r_cnt;
    logic [kmptt_pkg::SLOT_W-1:0]     n_cnt;
    logic                             r_out_valid;
    logic                             n_out_valid;
    kmptt_pkg::t_out                  r_out;
    kmptt_pkg::t_out                  n_out;
    logic                             out_free;
    logic                             accept;
    kmptt_pkg::t_tok                  best;

    assign tok[0] = '0;
    assign best   = tok[kmptt_pkg::TASK_SLOTS];

    for (genvar g = 0; g < kmptt_pkg::TASK_SLOTS; g++) begin : g_cell
        kmptt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (kmptt_pkg::SLOT_W'(g)),
            .i_cmd   (cmd),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_hit   (hits[g])
        );
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == kmptt_pkg::S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        cmd         = '0;
        cmd.key     = kmptt_pkg::CMP_W'(i_data.task_key);
        cmd.owner   = i_data.owner_in;
        cmd.prio    = i_data.prio_in;
        case (r_state)
            kmptt_pkg::S_IDLE: begin
                if (accept) begin
                    n_out.owner_out = '0;
                    n_out.status    = kmptt_pkg::ST_DONE;
                    case (i_data.mode)
                        kmptt_pkg::MODE_ADD: begin
                            cmd.add     = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        kmptt_pkg::MODE_EDIT: begin
                            cmd.edit     = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out.status = (|hits) ? kmptt_pkg::ST_DONE
                                                   : kmptt_pkg::ST_ABSENT;
                        end
                        kmptt_pkg::MODE_REMOVE: begin
                            cmd.clear   = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_state = kmptt_pkg::S_SCAN;
                            n_cnt   = '0;
                        end
                    endcase
                end
            end
            kmptt_pkg::S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == kmptt_pkg::SLOT_W'(kmptt_pkg::TASK_SLOTS - 2)) begin
                    n_state = kmptt_pkg::S_FIN;
                end
            end
            kmptt_pkg::S_FIN: begin
                // The token leaving the last cell now covers the whole table.
                if (out_free) begin
                    cmd.key     = kmptt_pkg::CMP_W'(best.idx);
                    cmd.clear   = best.found;
                    n_out_valid = 1'b1;
                    if (best.found) begin
                        n_out.owner_out = best.owner;
                        n_out.status    = kmptt_pkg::ST_DONE;
                    end else begin
                        n_out.owner_out = '0;
                        n_out.status    = kmptt_pkg::ST_EMPTY;
                    end
                    n_state = kmptt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kmptt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmptt_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### dv/keyed_max_priority_task_table_tb.sv
// Self-checking testbench for the keyed max-priority task table.
module keyed_max_priority_task_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CMDS   = 830;
    localparam int DRAIN_CYCLES  = kmptt_pkg::TASK_SLOTS + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        kmptt_pkg::t_in  cmd;
        bit              pinned;
        kmptt_pkg::t_out want;
    } t_dir_row;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b0;
    kmptt_pkg::t_in  i_data  = '0;
    logic            o_stall;
    logic            o_valid;
    kmptt_pkg::t_out o_data;

    // Shadow copy of the task table.
    bit                            slot_live  [kmptt_pkg::TASK_SLOTS];
    bit [kmptt_pkg::OWNER_W-1:0]   slot_owner [kmptt_pkg::TASK_SLOTS];
    bit [kmptt_pkg::PRIO_W-1:0]    slot_prio  [kmptt_pkg::TASK_SLOTS];

    kmptt_pkg::t_out owed_results [$];
    t_dir_row        dir_rows [$];
    kmptt_pkg::t_out owed_head;
    int              miss_cnt     = 0;
    int              cycle_cnt    = 0;
    int              snd_idle_pct = 20;
    int              rcv_idle_pct = 57;

    keyed_max_priority_task_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Applies one command to the shadow table and returns the outcome it owes.
    function automatic kmptt_pkg::t_out table_outcome(input kmptt_pkg::t_in cmd);
        kmptt_pkg::t_out           res;
        int                        key;
        int                        best;
        bit [kmptt_pkg::PRIO_W-1:0] best_prio;
        res        = '0;
        res.status = kmptt_pkg::ST_DONE;
        key        = int'(cmd.task_key);
        best       = -1;
        best_prio  = '0;
        case (cmd.mode)
            kmptt_pkg::MODE_ADD: begin
                if (key < kmptt_pkg::TASK_SLOTS) begin
                    slot_live[key]  = 1'b1;
                    slot_owner[key] = cmd.owner_in;
                    slot_prio[key]  = cmd.prio_in;
                end
            end
            kmptt_pkg::MODE_EDIT: begin
                if (key < kmptt_pkg::TASK_SLOTS && slot_live[key])
                    slot_prio[key] = cmd.prio_in;
                else
                    res.status = kmptt_pkg::ST_ABSENT;
            end
            kmptt_pkg::MODE_REMOVE: begin
                if (key < kmptt_pkg::TASK_SLOTS)
                    slot_live[key] = 1'b0;
            end
            default: begin
                // A later slot with an equal priority takes over the lead.
                for (int s = 0; s < kmptt_pkg::TASK_SLOTS; s++) begin
                    if (slot_live[s] && (best < 0 || slot_prio[s] >= best_prio)) begin
                        best      = s;
                        best_prio = slot_prio[s];
                    end
                end
                if (best >= 0) begin
                    res.owner_out   = slot_owner[best];
                    slot_live[best] = 1'b0;
                end else begin
                    res.status = kmptt_pkg::ST_EMPTY;
                end
            end
        endcase
        return res;
    endfunction

    function automatic kmptt_pkg::t_in mk_cmd(input logic [1:0] mode,
                                              input logic [kmptt_pkg::KEY_W-1:0] key,
                                              input logic [kmptt_pkg::OWNER_W-1:0] owner,
                                              input logic [kmptt_pkg::PRIO_W-1:0] prio);
        kmptt_pkg::t_in c;
        c.mode     = mode;
        c.task_key = key;
        c.owner_in = owner;
        c.prio_in  = prio;
        return c;
    endfunction

    function automatic kmptt_pkg::t_out mk_res(input logic [kmptt_pkg::OWNER_W-1:0] owner,
                                               input logic [kmptt_pkg::STATUS_W-1:0] status);
        kmptt_pkg::t_out r;
        r.owner_out = owner;
        r.status    = status;
        return r;
    endfunction

    // Alternates fill stretches and drain stretches so the table gets deep at times.
    function automatic kmptt_pkg::t_in random_cmd(input int idx);
        kmptt_pkg::t_in c;
        int             roll;
        int             proll;
        bit             filling;
        filling = ((idx / 48) % 2) == 0;
        roll    = $urandom_range(99);
        if (filling)
            c.mode = (roll < 55) ? kmptt_pkg::MODE_ADD : (roll < 70) ? kmptt_pkg::MODE_EDIT :
                     (roll < 80) ? kmptt_pkg::MODE_REMOVE : kmptt_pkg::MODE_EXEC;
        else
            c.mode = (roll < 15) ? kmptt_pkg::MODE_ADD : (roll < 30) ? kmptt_pkg::MODE_EDIT :
                     (roll < 45) ? kmptt_pkg::MODE_REMOVE : kmptt_pkg::MODE_EXEC;
        if ($urandom_range(99) < 60)
            c.task_key = kmptt_pkg::KEY_W'($urandom_range(31));
        else
            c.task_key = kmptt_pkg::KEY_W'($urandom_range(255));
        c.owner_in = kmptt_pkg::OWNER_W'($urandom);
        proll = $urandom_range(99);
        if (proll < 35)
            c.prio_in = kmptt_pkg::PRIO_W'($urandom_range(7));
        else if (proll < 45)
            c.prio_in = '1;
        else if (proll < 50)
            c.prio_in = '0;
        else
            c.prio_in = kmptt_pkg::PRIO_W'($urandom);
        return c;
    endfunction

    function automatic void log_miss(input string what, input kmptt_pkg::t_out want,
                                     input kmptt_pkg::t_out got);
        miss_cnt++;
        if (miss_cnt <= REPORT_MAX)
            $display("t=%0t %s: expected owner=%h status=%0d, got owner=%h status=%0d",
                     $realtime, what, want.owner_out, want.status,
                     got.owner_out, got.status);
    endfunction

    // Sends one command and records what it owes once the transaction is taken.
    task automatic send_cmd(input kmptt_pkg::t_in cmd, input bit pinned,
                            input kmptt_pkg::t_out want);
        kmptt_pkg::t_out guess;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= cmd;
        do @(posedge i_clk); while (o_stall);
        guess = table_outcome(cmd);
        owed_results.push_back(pinned ? want : guess);
    endtask

    // Result side: stall at random and check every accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    log_miss("result with nothing outstanding", '0, o_data);
                end else begin
                    owed_head = owed_results.pop_front();
                    if (o_data.owner_out !== owed_head.owner_out)
                        log_miss("owner_out mismatch", owed_head, o_data);
                    if (o_data.status !== owed_head.status)
                        log_miss("status mismatch", owed_head, o_data);
                end
            end
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h00, 16'h0000, 31'h0),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_EMPTY)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EDIT, 8'h05, 16'h1111, 31'h9),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_ABSENT)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_REMOVE, 8'h07, 16'h0000, 31'h0),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_DONE)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h00, 16'hFFFF, 31'h7FFF_FFFF),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_DONE)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'hFF, 16'h0000, 31'h7FFF_FFFF),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_DONE)});
        // Equal top priorities: the larger task id goes first.
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h00, 16'h0000, 31'h0),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_DONE)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h00, 16'h0000, 31'h0),
                             1'b1, mk_res(16'hFFFF, kmptt_pkg::ST_DONE)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h00, 16'h0000, 31'h0),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_EMPTY)});
        // Overwrite of a present entry, then a priority edit that reorders.
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h0A, 16'h1234, 31'h0),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h0A, 16'hABCD, 31'h5),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h14, 16'h5555, 31'h0),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EDIT, 8'h14, 16'h0000, 31'h7FFF_FFFF),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h14, 16'h0000, 31'h0),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h0A, 16'h0000, 31'h0),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h1E, 16'hAAAA, 31'h64),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_REMOVE, 8'h1E, 16'hFFFF, 31'h7FFF_FFFF),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h1E, 16'h0000, 31'h0),
                             1'b0, '0});
        // Fields that execute ignores are all ones here.
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF),
                             1'b1, mk_res(16'h0000, kmptt_pkg::ST_EMPTY)});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_ADD, 8'h28, 16'h0001, 31'h3),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EDIT, 8'h28, 16'hFFFF, 31'h2),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_REMOVE, 8'h29, 16'h5A5A, 31'h2AAA_AAAA),
                             1'b0, '0});
        dir_rows.push_back('{mk_cmd(kmptt_pkg::MODE_EXEC, 8'h28, 16'h0000, 31'h0),
                             1'b0, '0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_cmd(dir_rows[r].cmd, dir_rows[r].pinned, dir_rows[r].want);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n == RANDOM_CMDS / 3) begin
                snd_idle_pct = 57;
                rcv_idle_pct = 20;
            end else if (n == 2 * RANDOM_CMDS / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            send_cmd(random_cmd(n), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (miss_cnt == 0 && owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
rtl/kmptt_pkg.sv
rtl/kmptt_cell.sv
rtl/keyed_max_priority_task_table.sv
dv/keyed_max_priority_task_table_tb.sv
